FILE: src/ucdc_pkg.sv
// ----------------------------------------------------------------------------
// ucdc_pkg
// Shared types and constants for the USB CDC descriptor scanner.
// ----------------------------------------------------------------------------
package ucdc_pkg;

    localparam logic [7:0]  DESC_TYPE_INTERFACE = 8'h04;
    localparam logic [7:0]  DESC_TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0]  CLASS_COMM          = 8'h02;
    localparam logic [7:0]  CLASS_DATA          = 8'h0A;
    localparam logic [7:0]  EP_DIR_IN_MASK      = 8'h80;
    localparam logic [1:0]  XFER_BULK           = 2'b10;
    localparam logic [7:0]  IFACE_NONE          = 8'hFF;
    localparam logic [7:0]  EP_NONE             = 8'h00;
    localparam logic [15:0] DEFAULT_MPS         = 16'd64;
    localparam logic [7:0]  MIN_DESC_LEN        = 8'd2;
    localparam logic [7:0]  MIN_IFACE_LEN       = 8'd9;
    localparam logic [7:0]  MIN_EP_LEN          = 8'd7;
    localparam logic [15:0] POS_TOTAL_LO        = 16'd2;
    localparam logic [15:0] POS_TOTAL_HI        = 16'd3;
    localparam logic [15:0] POS_MAX             = 16'hFFFF;

    typedef struct packed {
        logic        ready_res;
        logic [7:0]  comm_interface;
        logic [7:0]  data_interface;
        logic [7:0]  in_endpoint;
        logic [15:0] in_max_packet;
        logic [7:0]  out_endpoint;
        logic [15:0] out_max_packet;
    } t_result;

endpackage

FILE: src/ucdc_parser.sv
// ----------------------------------------------------------------------------
// ucdc_parser
// Per-byte descriptor walker: tracks descriptor boundaries, captures fields,
// records comm/data interfaces and bulk endpoints, builds the result.
// ----------------------------------------------------------------------------
module ucdc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_result_valid,
    output ucdc_pkg::t_result o_result
);
    import ucdc_pkg::*;

    logic [15:0] r_pos,       n_pos;
    logic [15:0] r_total,     n_total;
    logic [7:0]  r_offset,    n_offset;
    logic [7:0]  r_len,       n_len;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_cap [4],   n_cap [4];
    logic        r_halted,    n_halted;
    logic [7:0]  r_cur_iface, n_cur_iface;
    logic [7:0]  r_cur_class, n_cur_class;
    logic [7:0]  r_comm,      n_comm;
    logic [7:0]  r_data,      n_data;
    logic [7:0]  r_in_addr,   n_in_addr;
    logic [15:0] r_in_mps,    n_in_mps;
    logic [7:0]  r_out_addr,  n_out_addr;
    logic [15:0] r_out_mps,   n_out_mps;
    t_result     result;

    always_comb begin
        n_pos       = r_pos;
        n_total     = r_total;
        n_offset    = r_offset;
        n_len       = r_len;
        n_type      = r_type;
        n_cap       = r_cap;
        n_halted    = r_halted;
        n_cur_iface = r_cur_iface;
        n_cur_class = r_cur_class;
        n_comm      = r_comm;
        n_data      = r_data;
        n_in_addr   = r_in_addr;
        n_in_mps    = r_in_mps;
        n_out_addr  = r_out_addr;
        n_out_mps   = r_out_mps;
        result      = '0;

        if (i_take) begin
            if (r_pos == POS_TOTAL_LO) begin
                n_total = {r_total[15:8], i_data_byte};
            end else if (r_pos == POS_TOTAL_HI) begin
                n_total = {i_data_byte, r_total[7:0]};
            end

            if (!r_halted) begin
                if (r_offset == 8'd0) begin
                    n_len = i_data_byte;
                    if (i_data_byte < MIN_DESC_LEN) begin
                        n_halted = 1'b1;
                    end else begin
                        n_offset = 8'd1;
                    end
                end else begin
                    if (r_offset == 8'd1) begin
                        n_type = i_data_byte;
                    end else if (r_offset <= 8'd5) begin
                        // bytes 2..5 of a descriptor land in slots 0..3
                        n_cap[r_offset[1:0] - 2'd2] = i_data_byte;
                    end

                    if ({1'b0, r_offset} + 9'd1 == {1'b0, r_len}) begin
                        n_offset = 8'd0;
                        // descriptors ending before byte 3 skip the total check
                        if (r_pos >= POS_TOTAL_HI) begin
                            if ({1'b0, r_pos} + 17'd1 > {1'b0, n_total}) begin
                                n_halted = 1'b1;
                            end else begin
                                if (n_type == DESC_TYPE_INTERFACE &&
                                    r_len >= MIN_IFACE_LEN) begin
                                    n_cur_iface = n_cap[0];
                                    n_cur_class = n_cap[3];
                                    if (n_cap[3] == CLASS_COMM && r_comm == IFACE_NONE) begin
                                        n_comm = n_cap[0];
                                    end
                                    if (n_cap[3] == CLASS_DATA && r_data == IFACE_NONE) begin
                                        n_data = n_cap[0];
                                    end
                                end else if (n_type == DESC_TYPE_ENDPOINT &&
                                             r_len >= MIN_EP_LEN &&
                                             r_cur_class == CLASS_DATA &&
                                             n_cap[1][1:0] == XFER_BULK) begin
                                    if ((n_cap[0] & EP_DIR_IN_MASK) != 8'd0) begin
                                        n_in_addr = n_cap[0];
                                        n_in_mps  = {n_cap[3], n_cap[2]};
                                    end else begin
                                        n_out_addr = n_cap[0];
                                        n_out_mps  = {n_cap[3], n_cap[2]};
                                    end
                                end
                                if ({1'b0, r_pos} + 17'd1 == {1'b0, n_total}) begin
                                    n_halted = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_offset = r_offset + 8'd1;
                    end
                end
            end

            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 16'd1;
            end

            if (i_last_byte) begin
                result.ready_res      = (n_data != IFACE_NONE) && (n_in_addr != EP_NONE) &&
                                        (n_out_addr != EP_NONE);
                result.comm_interface = n_comm;
                result.data_interface = n_data;
                result.in_endpoint    = n_in_addr;
                result.in_max_packet  = n_in_mps;
                result.out_endpoint   = n_out_addr;
                result.out_max_packet = n_out_mps;

                // start clean for the next descriptor set
                n_pos       = '0;
                n_total     = '0;
                n_offset    = '0;
                n_len       = '0;
                n_type      = '0;
                n_cap       = '{default: 8'd0};
                n_halted    = 1'b0;
                n_cur_iface = IFACE_NONE;
                n_cur_class = '0;
                n_comm      = IFACE_NONE;
                n_data      = IFACE_NONE;
                n_in_addr   = EP_NONE;
                n_in_mps    = DEFAULT_MPS;
                n_out_addr  = EP_NONE;
                n_out_mps   = DEFAULT_MPS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_total     <= '0;
            r_offset    <= '0;
            r_len       <= '0;
            r_type      <= '0;
            r_cap       <= '{default: 8'd0};
            r_halted    <= 1'b0;
            r_cur_iface <= IFACE_NONE;
            r_cur_class <= '0;
            r_comm      <= IFACE_NONE;
            r_data      <= IFACE_NONE;
            r_in_addr   <= EP_NONE;
            r_in_mps    <= DEFAULT_MPS;
            r_out_addr  <= EP_NONE;
            r_out_mps   <= DEFAULT_MPS;
        end else begin
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_offset    <= n_offset;
            r_len       <= n_len;
            r_type      <= n_type;
            r_cap       <= n_cap;
            r_halted    <= n_halted;
            r_cur_iface <= n_cur_iface;
            r_cur_class <= n_cur_class;
            r_comm      <= n_comm;
            r_data      <= n_data;
            r_in_addr   <= n_in_addr;
            r_in_mps    <= n_in_mps;
            r_out_addr  <= n_out_addr;
            r_out_mps   <= n_out_mps;
        end
    end

    assign o_result_valid = i_take && i_last_byte;
    assign o_result       = result;

    // inside a descriptor the offset always stays below its length
    a_offset_in_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset != 8'd0 |-> (r_len >= MIN_DESC_LEN && r_offset < r_len))
        else $error("descriptor offset outside descriptor");

    // a halted walk never sits mid-descriptor
    a_halt_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_offset == 8'd0)
        else $error("halted inside a descriptor");

    // the last byte leaves the walker in its reset state
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_byte) |=> (r_pos == 16'd0 && !r_halted &&
                                     r_comm == IFACE_NONE && r_data == IFACE_NONE))
        else $error("state not cleared after last byte");

    // the data interface, once found, is never replaced within a set
    a_data_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_data != IFACE_NONE && !(i_take && i_last_byte)) |=> $stable(r_data))
        else $error("data interface overwritten");

endmodule

FILE: src/ucdc_out_reg.sv
// ----------------------------------------------------------------------------
// ucdc_out_reg
// Result register holding one transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module ucdc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ucdc_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output ucdc_pkg::t_result o_result
);
    import ucdc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or being taken this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: src/usb_cdc_descriptor_scanner_top.sv
// ----------------------------------------------------------------------------
// usb_cdc_descriptor_scanner_top
// Scans a USB configuration descriptor set for the CDC comm/data interfaces
// and the bulk IN/OUT endpoints of the data interface.
// ----------------------------------------------------------------------------
// One descriptor byte is taken per clock. A byte passes through an input
// register and is folded into the walker state once it is accepted. The byte
// marked last produces one result transaction, which is offered from the
// cycle after acceptance and is held in an output register until taken.
// Non-final bytes never wait. A final byte waits in the input register only
// while the previous result is still stalled at the output, and the input
// stalls only for that time. After each result all state is back at reset.
// ----------------------------------------------------------------------------
module usb_cdc_descriptor_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ready_res,
    output logic [7:0]  o_comm_interface,
    output logic [7:0]  o_data_interface,
    output logic [7:0]  o_in_endpoint,
    output logic [15:0] o_in_max_packet,
    output logic [7:0]  o_out_endpoint,
    output logic [15:0] o_out_max_packet
);
    import ucdc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // a non-final byte always advances; a final one needs the output slot
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ucdc_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (advance),
        .i_data_byte    (r_in_byte),
        .i_last_byte    (r_in_last),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    ucdc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign o_ready_res      = out_res.ready_res;
    assign o_comm_interface = out_res.comm_interface;
    assign o_data_interface = out_res.data_interface;
    assign o_in_endpoint    = out_res.in_endpoint;
    assign o_in_max_packet  = out_res.in_max_packet;
    assign o_out_endpoint   = out_res.out_endpoint;
    assign o_out_max_packet = out_res.out_max_packet;

endmodule
